// File: rtl/bbpe_pkg.sv
// Types, constants and reset grid shared by the Bezier patch evaluator.
`timescale 1ns / 1ps
package bbpe_pkg;

  localparam int CoordWidth    = 16;
  localparam int ParamFracBits = 16;
  localparam int NumPoints     = 9;
  localparam int IndexWidth    = 4;

  localparam logic signed [CoordWidth-1:0] CoordOne      = CoordWidth'(256);
  localparam logic signed [CoordWidth-1:0] CoordOneHalf  = CoordWidth'(384);
  localparam logic signed [CoordWidth-1:0] CoordTwo      = CoordWidth'(512);
  localparam logic signed [CoordWidth-1:0] CoordZero     = '0;
  localparam logic signed [CoordWidth-1:0] CoordMinusOne = -CoordWidth'(256);

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_e;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [ParamFracBits:0]       param_t;
  typedef param_t [2:0]                 wvec_t;

  typedef struct packed {
    func_e                 func;
    logic [IndexWidth-1:0] point_index;
    coord_t                point_x;
    coord_t                point_y;
    coord_t                point_z;
    param_t                param_u;
    param_t                param_v;
  } in_t;

  typedef struct packed {
    coord_t surf_x;
    coord_t surf_y;
    coord_t surf_z;
  } out_t;

  function automatic coord_t dome_coord(int idx, int axis);
    coord_t v;
    v = CoordZero;
    case (axis)
      0: begin
        case (idx % 3)
          0: v = CoordOne;
          2: v = CoordMinusOne;
          default: v = CoordZero;
        endcase
      end
      1: begin
        case (idx)
          4: v = CoordTwo;
          1, 7: v = CoordOneHalf;
          default: v = CoordOne;
        endcase
      end
      default: begin
        case (idx / 3)
          0: v = CoordMinusOne;
          2: v = CoordOne;
          default: v = CoordZero;
        endcase
      end
    endcase
    return v;
  endfunction

endpackage

// File: rtl/bbpe_weight.sv
// Two-stage Bernstein weight generator for one surface parameter.
`timescale 1ns / 1ps
module bbpe_weight
  import bbpe_pkg::*;
(
  input  logic   clk_i,
  input  logic   en_i,
  input  param_t t_i,
  output wvec_t  w_o
);

  localparam param_t ParamOne = param_t'(1) << ParamFracBits;
  localparam int     ProdW    = 2 * (ParamFracBits + 1);

  param_t t_d, t_q, omt_d, omt_q;
  wvec_t  w_d, w_q;
  logic [ProdW-1:0] p_omt_omt, p_omt_t, p_t_t;

  always_comb begin
    t_d   = (t_i > ParamOne) ? ParamOne : t_i;
    omt_d = ParamOne - t_d;
  end

  always_comb begin
    p_omt_omt = ProdW'(omt_q) * ProdW'(omt_q);
    p_omt_t   = ProdW'(omt_q) * ProdW'(t_q);
    p_t_t     = ProdW'(t_q) * ProdW'(t_q);
    w_d[0]    = param_t'(p_omt_omt >> ParamFracBits);
    w_d[1]    = param_t'(p_omt_t >> (ParamFracBits - 1));
    w_d[2]    = param_t'(p_t_t >> ParamFracBits);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= t_d;
      omt_q <= omt_d;
      w_q   <= w_d;
    end
  end

  assign w_o = w_q;

endmodule

// File: rtl/bbpe_dot3.sv
// Two-stage three-term weighted sum with floor shift by the weight scale.
`timescale 1ns / 1ps
module bbpe_dot3
  import bbpe_pkg::*;
#(
  parameter int InWidth = 16
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [InWidth-1:0] a_i [3],
  input  wvec_t                     w_i,
  output logic signed [InWidth+1:0] sum_o
);

  localparam int ProdW = InWidth + ParamFracBits + 2;
  localparam int SumW  = ProdW + 2;

  logic signed [ProdW-1:0] prod_d [3];
  logic signed [ProdW-1:0] prod_q [3];
  logic signed [SumW-1:0]  sum_full;
  logic signed [SumW-1:0]  sum_sh;
  logic signed [InWidth+1:0] sum_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = a_i[k] * $signed({1'b0, w_i[k]});
    end
  end

  always_comb begin
    sum_full = SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2]);
    sum_sh   = sum_full >>> ParamFracBits;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sum_q  <= sum_sh[InWidth+1:0];
    end
  end

  assign sum_o = sum_q;

endmodule

// File: rtl/biquadratic_bezier_patch_eval_core.sv
// Biquadratic Bezier patch evaluator: control point store and blend pipeline.
// Throughput: one item per cycle while the output is not stalled; seven register stages.
// Output stall holds every stage; nothing is dropped or repeated.
// Load items with an in-range point index write the store at transfer and are seen by the next item.
// Reset empties the pipeline and restores the dome-shaped control grid.
`timescale 1ns / 1ps
module biquadratic_bezier_patch_eval_core
  import bbpe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int RowW = CoordWidth + 2;
  localparam int ColW = CoordWidth + 4;
  localparam int NumStages = 7;

  logic en;
  logic in_xfer;
  logic eval_xfer;
  logic [NumStages:1] vld_q;

  coord_t store_q [NumPoints][3];
  coord_t pts_s1_q [NumPoints][3];
  coord_t pts_s2_q [NumPoints][3];

  wvec_t wu, wv, wu_s3_q, wu_s4_q;

  logic signed [RowW-1:0] row_val [3][3];
  logic signed [RowW-1:0] col_in [3][3];
  logic signed [ColW-1:0] col_val [3];
  coord_t sat_d [3];
  out_t   out_q;

  assign en         = !(vld_q[NumStages] && out_stall_i);
  assign in_stall_o = !en;
  assign in_xfer    = in_valid_i && en;
  assign eval_xfer  = in_xfer && (in_data_i.func == FUNC_EVAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPoints; i++) begin
        for (int c = 0; c < 3; c++) begin
          store_q[i][c] <= dome_coord(i, c);
        end
      end
    end else if (in_xfer && (in_data_i.func == FUNC_LOAD) &&
                 (in_data_i.point_index < IndexWidth'(NumPoints))) begin
      store_q[in_data_i.point_index][0] <= in_data_i.point_x;
      store_q[in_data_i.point_index][1] <= in_data_i.point_y;
      store_q[in_data_i.point_index][2] <= in_data_i.point_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-1:1], eval_xfer};
    end
  end

  bbpe_weight u_weight_u (
    .clk_i (clk_i),
    .en_i  (en),
    .t_i   (in_data_i.param_u),
    .w_o   (wu)
  );

  bbpe_weight u_weight_v (
    .clk_i (clk_i),
    .en_i  (en),
    .t_i   (in_data_i.param_v),
    .w_o   (wv)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      pts_s1_q <= store_q;
      pts_s2_q <= pts_s1_q;
      wu_s3_q  <= wu;
      wu_s4_q  <= wu_s3_q;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_axis
    for (genvar r = 0; r < 3; r++) begin : g_row
      coord_t row_pts [3];
      assign row_pts[0] = pts_s2_q[r*3+0][c];
      assign row_pts[1] = pts_s2_q[r*3+1][c];
      assign row_pts[2] = pts_s2_q[r*3+2][c];
      assign col_in[c][r] = row_val[c][r];

      bbpe_dot3 #(
        .InWidth (CoordWidth)
      ) u_row (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (row_pts),
        .w_i   (wv),
        .sum_o (row_val[c][r])
      );
    end

    bbpe_dot3 #(
      .InWidth (RowW)
    ) u_col (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (col_in[c]),
      .w_i   (wu_s4_q),
      .sum_o (col_val[c])
    );

    always_comb begin
      if (col_val[c][ColW-1:CoordWidth-1] == '0 ||
          col_val[c][ColW-1:CoordWidth-1] == '1) begin
        sat_d[c] = col_val[c][CoordWidth-1:0];
      end else if (col_val[c][ColW-1]) begin
        sat_d[c] = {1'b1, {(CoordWidth-1){1'b0}}};
      end else begin
        sat_d[c] = {1'b0, {(CoordWidth-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.surf_x <= sat_d[0];
      out_q.surf_y <= sat_d[1];
      out_q.surf_z <= sat_d[2];
    end
  end

  assign out_valid_o = vld_q[NumStages];
  assign out_data_o  = out_q;

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.func == FUNC_LOAD) |=> !vld_q[1])
    else $error("load transfer entered the blend pipeline");

  a_eval_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_xfer |=> vld_q[1])
    else $error("evaluate transfer did not enter the blend pipeline");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStages] && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline advanced during output stall");

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(store_q[0][0]) && $stable(store_q[8][2]))
    else $error("store written while output stalled");

endmodule
